>>> design/bcd_calendar_to_epoch_seconds_unit_macros.svh
// Assertion macros shared by the BCD calendar to epoch seconds design.
`ifndef BCD_CALENDAR_TO_EPOCH_SECONDS_UNIT_MACROS_SVH
`define BCD_CALENDAR_TO_EPOCH_SECONDS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BCDCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BCDCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bcdce_pkg.sv
// Package: widths, constants and decode helpers for the BCD calendar to epoch converter.
package bcdce_pkg;

    localparam int FIELD_W = 8;
    localparam int EPOCH_W = 32;
    localparam int DAYS_W  = 16;

    localparam logic [EPOCH_W-1:0] BASE_2000_SECONDS = 32'd946684800;
    localparam logic [DAYS_W-1:0]  MAX_LEGAL_DAYS    = 16'd36524;

    // BCD byte with bit 7 ignored, non-decimal nibbles taken at face value
    function automatic logic [6:0] bcd7(input logic [FIELD_W-1:0] v);
        return 7'(v[3:0]) + 7'(v[6:4]) * 7'd10;
    endfunction

    // Full BCD byte
    function automatic logic [7:0] bcd8(input logic [FIELD_W-1:0] v);
        return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
    endfunction

    // Days in the year before the first of month m (m already clamped to 0..12)
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            default:    d = 9'd334;
        endcase
        return d;
    endfunction

    typedef struct packed {
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hour;
        logic       bad;
    } t_time_info;

endpackage

>>> design/bcdce_if.sv
// Valid/ready channel interfaces for register sets in and epoch results out.
interface bcdce_in_if;
    import bcdce_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] second_bcd;
    logic [FIELD_W-1:0] minute_bcd;
    logic [FIELD_W-1:0] hour_code;
    logic [FIELD_W-1:0] date_bcd;
    logic [FIELD_W-1:0] month_code;
    logic [FIELD_W-1:0] year_bcd;

    modport source (
        output valid, second_bcd, minute_bcd, hour_code, date_bcd, month_code, year_bcd,
        input  ready
    );
    modport sink (
        input  valid, second_bcd, minute_bcd, hour_code, date_bcd, month_code, year_bcd,
        output ready
    );
endinterface

interface bcdce_out_if;
    import bcdce_pkg::*;

    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;
    logic [DAYS_W-1:0]  days_since_base;
    logic               bad_field;

    modport source (
        output valid, epoch_seconds, days_since_base, bad_field,
        input  ready
    );
    modport sink (
        input  valid, epoch_seconds, days_since_base, bad_field,
        output ready
    );
endinterface

>>> design/bcd_calendar_to_epoch_seconds_unit.sv
// Top level: five-stage pipeline converting BCD clock registers to Unix seconds.
//
// Usage:
//   i_in  carries one set of clock registers (second, minute, hour, date, month,
//         year) per transfer; o_out carries epoch_seconds, days_since_base and
//         bad_field, one result per input transfer, in order.
//   Result path: an accepted set moves through the stage registers r_v1 to r_v5 in
//   order; o_out.valid is r_v5, and the result transfers while o_out.ready is high.
//   Throughput: one transfer per cycle while o_out takes results; the stages are
//   decode and month lookup, day count, days*24, hours*60, minutes*60 plus base, each closed by a register.
//   Every stage advances when it is empty or its successor advances, so a stall
//   at o_out backs up stage by stage; i_in.ready drops only once all five stages
//   hold items. Nothing is dropped or repeated during a stall.
//   Reset (i_rst_n low, synchronous) empties the pipeline; the data registers are not reset.
//   bad_field marks any decoded field out of range; the result is still produced.
module bcd_calendar_to_epoch_seconds_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcdce_in_if.sink    i_in,
    bcdce_out_if.source o_out
);
    import bcdce_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic s1_en, s2_en, s3_en, s4_en, s5_en;

    assign s5_en = !r_v5 || o_out.ready;
    assign s4_en = !r_v4 || s5_en;
    assign s3_en = !r_v3 || s4_en;
    assign s2_en = !r_v2 || s3_en;
    assign s1_en = !r_v1 || s2_en;
    assign i_in.ready = s1_en;

    // Stage 1: decode, range check, month lookup
    t_time_info r_t1, n_t1;
    logic [6:0] r_date1, n_date1;
    logic [8:0] r_mstart1, n_mstart1;
    logic       r_leap1, n_leap1;
    logic [7:0] r_yr1, n_yr1;

    logic [6:0] mon;
    logic [4:0] clk12;
    logic [3:0] mclamp;

    always_comb begin
        n_t1.sec  = bcd7(i_in.second_bcd);
        n_t1.min  = bcd7(i_in.minute_bcd);
        n_date1   = bcd7(i_in.date_bcd);
        mon       = bcd7(i_in.month_code);
        n_yr1     = bcd8(i_in.year_bcd);
        clk12     = 5'(i_in.hour_code[3:0]) + (i_in.hour_code[4] ? 5'd10 : 5'd0);
        n_t1.bad  = 1'b0;
        if (i_in.hour_code[6]) begin
            n_t1.hour = ((clk12 == 5'd12) ? 6'd0 : 6'(clk12))
                      + (i_in.hour_code[5] ? 6'd12 : 6'd0);
            if (clk12 < 5'd1 || clk12 > 5'd12) begin
                n_t1.bad = 1'b1;
            end
        end else begin
            n_t1.hour = 6'(i_in.hour_code[3:0]) + 6'(i_in.hour_code[5:4]) * 6'd10;
            if (n_t1.hour > 6'd23) begin
                n_t1.bad = 1'b1;
            end
        end
        if (n_t1.sec > 7'd59 || n_t1.min > 7'd59 || n_date1 < 7'd1 || n_date1 > 7'd31
            || mon < 7'd1 || mon > 7'd12 || n_yr1 > 8'd99) begin
            n_t1.bad = 1'b1;
        end
        mclamp    = (mon > 7'd12) ? 4'd12 : mon[3:0];
        n_mstart1 = month_start(mclamp);
        n_leap1   = (mon > 7'd2) && (n_yr1[1:0] == 2'b00);
    end

    // Stage 2: whole days since 2000-01-01, modulo 2^16
    t_time_info          r_t2;
    logic [DAYS_W-1:0]   r_days2, n_days2;
    logic [DAYS_W:0]     day_sum;

    always_comb begin
        day_sum = 17'(r_date1) + 17'(r_mstart1) + 17'(r_leap1)
                + 17'(r_yr1) * 17'd365 + 17'((9'(r_yr1) + 9'd3) >> 2) - 17'd1;
        n_days2 = day_sum[DAYS_W-1:0];
    end

    // Stages 3 to 5: hours, minutes, seconds
    t_time_info          r_t3, r_t4;
    logic [DAYS_W-1:0]   r_days3, r_days4, r_days5;
    logic                r_bad5;
    logic [20:0]         r_hours3, n_hours3;
    logic [26:0]         r_mins4, n_mins4;
    logic [EPOCH_W-1:0]  r_secs5, n_secs5;

    assign n_hours3 = 21'(r_days2) * 21'd24 + 21'(r_t2.hour);
    assign n_mins4  = 27'(r_hours3) * 27'd60 + 27'(r_t3.min);
    assign n_secs5  = 32'(r_mins4) * 32'd60 + 32'(r_t4.sec) + BASE_2000_SECONDS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s1_en) r_v1 <= i_in.valid;
            if (s2_en) r_v2 <= r_v1;
            if (s3_en) r_v3 <= r_v2;
            if (s4_en) r_v4 <= r_v3;
            if (s5_en) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_t1      <= n_t1;
            r_date1   <= n_date1;
            r_mstart1 <= n_mstart1;
            r_leap1   <= n_leap1;
            r_yr1     <= n_yr1;
        end
        if (s2_en) begin
            r_t2    <= r_t1;
            r_days2 <= n_days2;
        end
        if (s3_en) begin
            r_t3     <= r_t2;
            r_days3  <= r_days2;
            r_hours3 <= n_hours3;
        end
        if (s4_en) begin
            r_t4    <= r_t3;
            r_days4 <= r_days3;
            r_mins4 <= n_mins4;
        end
        if (s5_en) begin
            r_days5 <= r_days4;
            r_bad5  <= r_t4.bad;
            r_secs5 <= n_secs5;
        end
    end

    assign o_out.valid           = r_v5;
    assign o_out.epoch_seconds   = r_secs5;
    assign o_out.days_since_base = r_days5;
    assign o_out.bad_field       = r_bad5;

`include "bcd_calendar_to_epoch_seconds_unit_macros.svh"

    `BCDCE_ASSERT_NOW(a_no_bubble_stall, !r_v5, i_in.ready,
        "input stalled while output stage empty")
    `BCDCE_ASSERT_NEXT(a_stage2_hold, r_v2 && !s3_en, r_v2 && $stable(r_days2),
        "stage 2 lost or changed a stalled item")
    `BCDCE_ASSERT_NOW(a_legal_range, r_v5 && !r_bad5,
        r_days5 <= MAX_LEGAL_DAYS && r_secs5 >= BASE_2000_SECONDS,
        "legal date produced out-of-range result")

endmodule

>>> tb/bcd_calendar_to_epoch_seconds_unit_test.sv
// Testbench: BCD clock registers to epoch seconds, checked against a built-in predictor.
`timescale 1ns / 1ps

module bcd_calendar_to_epoch_seconds_unit_test;
    import bcdce_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [DAYS_W-1:0]  days;
        logic               bad;
    } t_epoch_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bcdce_in_if  in_ch ();
    bcdce_out_if out_ch ();

    bcd_calendar_to_epoch_seconds_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_epoch_res  expected_results[$];
    t_epoch_res  want_res;
    int unsigned err_cnt      = 0;
    int unsigned accepted_cnt = 0;
    int unsigned flagged_cnt  = 0;
    int unsigned checked_cnt  = 0;
    bit          gaps_on      = 1'b1;
    bit          stalls_on    = 1'b1;
    bit          hold_req     = 1'b0;

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Expected conversion of one register set
    function automatic t_epoch_res predict_epoch(
        input logic [7:0] s, input logic [7:0] mi, input logic [7:0] h,
        input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y
    );
        int unsigned sec_v, min_v, date_v, mon_v, yr_v, hr_v, clk_v, days_v, cap;
        bit          flag;
        t_epoch_res  res;
        flag   = 1'b0;
        sec_v  = int'(s[3:0])  + 10 * int'(s[6:4]);
        min_v  = int'(mi[3:0]) + 10 * int'(mi[6:4]);
        date_v = int'(d[3:0])  + 10 * int'(d[6:4]);
        mon_v  = int'(mo[3:0]) + 10 * int'(mo[6:4]);
        yr_v   = int'(y[3:0])  + 10 * int'(y[7:4]);
        if (h[6]) begin
            clk_v = int'(h[3:0]) + 10 * int'(h[4]);
            if (clk_v < 1 || clk_v > 12) flag = 1'b1;
            hr_v = (clk_v == 12) ? 0 : clk_v;
            if (h[5]) hr_v += 12;
        end else begin
            hr_v = int'(h[3:0]) + 10 * int'(h[5:4]);
            if (hr_v > 23) flag = 1'b1;
        end
        if (sec_v > 59 || min_v > 59) flag = 1'b1;
        if (date_v < 1 || date_v > 31) flag = 1'b1;
        if (mon_v < 1 || mon_v > 12) flag = 1'b1;
        if (yr_v > 99) flag = 1'b1;
        cap    = (mon_v > 12) ? 12 : mon_v;
        days_v = date_v;
        for (int i = 1; i < cap; i++) days_v += MONTH_DAYS[i-1];
        if (mon_v > 2 && (yr_v % 4) == 0) days_v += 1;
        days_v = (days_v + 365 * yr_v + (yr_v + 3) / 4 - 1) & 32'h0000_FFFF;
        res.epoch = ((days_v * 24 + hr_v) * 60 + min_v) * 60 + sec_v + BASE_2000_SECONDS;
        res.days  = days_v[DAYS_W-1:0];
        res.bad   = flag;
        return res;
    endfunction

    // Scoreboard: check results first, then record the new input transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual epoch=%0d days=%0d bad=%0b",
                             $time, out_ch.epoch_seconds, out_ch.days_since_base, out_ch.bad_field);
                    err_cnt++;
                end else begin
                    want_res = expected_results.pop_front();
                    checked_cnt++;
                    if (out_ch.epoch_seconds !== want_res.epoch) begin
                        $display("%0t: epoch_seconds expected %0d actual %0d",
                                 $time, want_res.epoch, out_ch.epoch_seconds);
                        err_cnt++;
                    end
                    if (out_ch.days_since_base !== want_res.days) begin
                        $display("%0t: days_since_base expected %0d actual %0d",
                                 $time, want_res.days, out_ch.days_since_base);
                        err_cnt++;
                    end
                    if (out_ch.bad_field !== want_res.bad) begin
                        $display("%0t: bad_field expected %0b actual %0b",
                                 $time, want_res.bad, out_ch.bad_field);
                        err_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                want_res = predict_epoch(in_ch.second_bcd, in_ch.minute_bcd, in_ch.hour_code,
                                         in_ch.date_bcd, in_ch.month_code, in_ch.year_bcd);
                expected_results.push_back(want_res);
                accepted_cnt++;
                if (want_res.bad) flagged_cnt++;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= !(stalls_on && $urandom_range(0, 99) < 22);
            end
        end
    end

    task automatic send_regs(
        input logic [7:0] s, input logic [7:0] mi, input logic [7:0] h,
        input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y
    );
        while (gaps_on && $urandom_range(0, 99) < 22) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.second_bcd <= s;
        in_ch.minute_bcd <= mi;
        in_ch.hour_code  <= h;
        in_ch.date_bcd   <= d;
        in_ch.month_code <= mo;
        in_ch.year_bcd   <= y;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Legal register set with random content; unused bit 7 set at random
    task automatic send_legal_random();
        logic [7:0] h;
        logic [7:0] mo;
        if ($urandom_range(0, 1)) begin
            h = to_bcd($urandom_range(0, 23));
        end else begin
            h = 8'h40 | to_bcd($urandom_range(1, 12));
            h[5] = 1'($urandom_range(0, 1));
        end
        h[7] = 1'($urandom_range(0, 1));
        mo = to_bcd($urandom_range(1, 12));
        mo[7] = 1'($urandom_range(0, 1));
        send_regs(to_bcd($urandom_range(0, 59)) | {1'($urandom_range(0, 1)), 7'd0},
                  to_bcd($urandom_range(0, 59)) | {1'($urandom_range(0, 1)), 7'd0},
                  h,
                  to_bcd($urandom_range(1, 31)) | {1'($urandom_range(0, 1)), 7'd0},
                  mo,
                  to_bcd($urandom_range(0, 99)));
    endtask

    task automatic test_directed();
        send_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // day count wraps
        send_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00); // base date
        send_regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);
        send_regs(8'h08, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38); // past signed 32-bit range
        send_regs(8'h00, 8'h00, 8'h52, 8'h15, 8'h06, 8'h10); // 12 AM
        send_regs(8'h00, 8'h00, 8'h72, 8'h15, 8'h06, 8'h10); // 12 PM
        send_regs(8'h30, 8'h30, 8'h41, 8'h15, 8'h06, 8'h10);
        send_regs(8'h30, 8'h30, 8'h71, 8'h15, 8'h06, 8'h10);
        send_regs(8'h00, 8'h00, 8'h40, 8'h15, 8'h06, 8'h10); // 12h clock zero
        send_regs(8'h00, 8'h00, 8'h60, 8'h15, 8'h06, 8'h10);
        send_regs(8'h00, 8'h00, 8'h53, 8'h15, 8'h06, 8'h10);
        send_regs(8'h00, 8'h00, 8'h5F, 8'h15, 8'h06, 8'h10);
        send_regs(8'h00, 8'h00, 8'h24, 8'h15, 8'h06, 8'h10);
        send_regs(8'h00, 8'h00, 8'h3F, 8'h15, 8'h06, 8'h10);
        send_regs(8'h4F, 8'h5A, 8'h0C, 8'h15, 8'h06, 8'h10); // non-decimal nibbles
        send_regs(8'h60, 8'h60, 8'h12, 8'h15, 8'h00, 8'h10); // month zero
        send_regs(8'h00, 8'h00, 8'h12, 8'h15, 8'h13, 8'h10); // month clamped
        send_regs(8'h00, 8'h00, 8'h12, 8'h15, 8'h7F, 8'h11);
        send_regs(8'h00, 8'h00, 8'h12, 8'h15, 8'h81, 8'h11); // century flag
        send_regs(8'h00, 8'h00, 8'h12, 8'h31, 8'h02, 8'h23); // date past month end
        send_regs(8'h00, 8'h00, 8'h12, 8'h32, 8'h02, 8'h23);
        send_regs(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'h24); // leap year
        send_regs(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h24);
        send_regs(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'hA0); // year 100
        send_regs(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'h9F);
    endtask

    task automatic test_random_mix(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 75) begin
                send_legal_random();
            end else begin
                send_regs(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_back_to_back(input int unsigned n);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (int i = 0; i < n; i++) send_legal_random();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Receiver holds off while transfers keep coming: pipeline fills, input stalls
    task automatic test_output_backpressure(input int unsigned n);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        test_random_mix(n);
        gaps_on  = 1'b1;
    endtask

    initial begin
        int unsigned wait_cycles;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.second_bcd <= 8'h00;
        in_ch.minute_bcd <= 8'h00;
        in_ch.hour_code  <= 8'h00;
        in_ch.date_bcd   <= 8'h00;
        in_ch.month_code <= 8'h00;
        in_ch.year_bcd   <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(130);
        test_back_to_back(80);
        test_output_backpressure(30);
        test_random_mix(130);

        in_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            err_cnt++;
        end
        repeat (10) @(posedge i_clk);

        $display("Converted %0d register sets (%0d with out-of-range fields), %0d results checked.",
                 accepted_cnt, flagged_cnt, checked_cnt);
        $display("Covered 12/24-hour decode, date and month extremes, wraps, gaps and backpressure.");
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("%0t: timeout", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
